FILE: rtl/bspline_gram_banded_multiply_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the B-spline Gram banded multiply.
// Concurrent assertions are written with these macros, one use to a line.
// ----------------------------------------------------------------------------
`ifndef BSPLINE_GRAM_BANDED_MULTIPLY_ASSERT_SVH
`define BSPLINE_GRAM_BANDED_MULTIPLY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BGBM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BGBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bgbm_pkg.sv
// ----------------------------------------------------------------------------
// bgbm_pkg
// Types, constants and the coefficient lookup of the banded Gram multiply.
// ----------------------------------------------------------------------------
`default_nettype none

package bgbm_pkg;

    // Field widths.
    localparam int SAMPLE_W    = 32;
    localparam int LEN_W       = 17;
    localparam int ROW_W       = 16;
    localparam int COEF_W      = 30;
    localparam int FRAC_BITS   = 30;
    localparam int TAPS        = 5;
    localparam int WIN_DEPTH   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int SUM_W       = PROD_W + 3;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_LENGTH   = 2'd0;
    localparam logic [1:0] REG_ORDER    = 2'd1;
    localparam logic [1:0] REG_BOUNDARY = 2'd2;

    // Boundary modes and the order code that selects the pentadiagonal stencil.
    localparam logic [1:0] MODE_RIGHT_FREE = 2'd1;
    localparam logic [1:0] MODE_LEFT_FREE  = 2'd2;
    localparam logic [1:0] ORDER_PENTA     = 2'd3;

    // Vector length limits and reset values.
    localparam logic [LEN_W-1:0] MIN_LENGTH   = 17'd5;
    localparam logic [LEN_W-1:0] MAX_LENGTH   = 17'd65536;
    localparam logic [1:0]       RESET_ORDER  = 2'd2;
    localparam logic [1:0]       RESET_MODE   = 2'd0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [COEF_W-1:0]          coef_t;
    typedef logic [ROW_W-1:0]           row_t;
    typedef logic [LEN_W-1:0]           len_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    // Q0.30 coefficients, rounded to nearest.
    localparam coef_t Q_TWO_THIRDS  = 30'd715827883;
    localparam coef_t Q_SIXTH       = 30'd178956971;
    localparam coef_t Q_THIRD       = 30'd357913941;
    localparam coef_t Q_11_20       = 30'd590558003;
    localparam coef_t Q_13_60       = 30'd232644062;
    localparam coef_t Q_1_120       = 30'd8947849;
    localparam coef_t Q_5_24        = 30'd223696213;
    localparam coef_t Q_7_60        = 30'd125269879;
    localparam coef_t Q_FIFTH       = 30'd214748365;
    localparam coef_t Q_1_60        = 30'd17895697;

    // Order 3 stencil: interior by distance, and corner blocks of the two end types.
    localparam coef_t INTERIOR3 [3] = '{Q_11_20, Q_13_60, Q_1_120};
    localparam coef_t HOMOG3 [3][3] = '{
        '{Q_THIRD, Q_5_24, Q_1_120},
        '{Q_5_24, Q_11_20, Q_13_60},
        '{Q_1_120, Q_13_60, Q_11_20}};
    localparam coef_t FREE3 [3][3] = '{
        '{Q_FIFTH, Q_7_60, Q_1_60},
        '{Q_7_60, Q_THIRD, Q_5_24},
        '{Q_1_60, Q_5_24, Q_11_20}};

    // Active configuration as the datapath sees it.
    typedef struct packed {
        logic       ord3;
        logic [1:0] mode;
        len_t       len;
    } cfg_t;

    // One job: the newest five samples (tap j holds column k-j) and the sample index.
    typedef struct packed {
        sample_t [TAPS-1:0] taps;
        row_t               k;
        logic               last;
    } job_t;

    // Write side of the job queue.
    typedef struct packed {
        logic push;
        job_t job;
    } queue_wr_t;

    // Read side of the job queue.
    typedef struct packed {
        logic valid;
        job_t job;
    } queue_rd_t;

    // Row tag that travels with a product through the pipeline.
    typedef struct packed {
        row_t row;
        logic eov;
    } tag_t;

    // Gram matrix entry for row and column row+d; zero outside the matrix.
    function automatic coef_t coef_fn(input cfg_t cfg, input row_t row,
                                      input logic signed [2:0] d);
        logic signed [LEN_W+1:0] col;
        logic signed [LEN_W+1:0] last_idx;
        logic signed [LEN_W+1:0] row_s;
        logic signed [LEN_W+1:0] rr;
        logic signed [LEN_W+1:0] rc;
        logic [2:0]              ad;
        logic                    left_free;
        logic                    right_free;
        coef_t                   w;
        row_s      = $signed({3'b000, row});
        col        = row_s + (LEN_W+2)'(d);
        last_idx   = $signed({2'b00, cfg.len}) - (LEN_W+2)'(1);
        rr         = last_idx - row_s;
        rc         = last_idx - col;
        ad         = d[2] ? 3'(-d) : 3'(d);
        left_free  = (cfg.mode == MODE_LEFT_FREE);
        right_free = (cfg.mode == MODE_RIGHT_FREE);
        w          = '0;
        if (col < 0 || col > last_idx) begin
            w = '0;
        end
        else if (!cfg.ord3) begin
            if (ad == 3'd1) begin
                w = Q_SIXTH;
            end
            else if (ad == 3'd0) begin
                w = ((left_free && row == '0) || (right_free && rr == 0)) ?
                    Q_THIRD : Q_TWO_THIRDS;
            end
        end
        else if (row <= 2 && col <= 2) begin
            w = left_free ? FREE3[row[1:0]][col[1:0]] : HOMOG3[row[1:0]][col[1:0]];
        end
        else if (rr <= 2 && rc <= 2) begin
            w = right_free ? FREE3[rr[1:0]][rc[1:0]] : HOMOG3[rr[1:0]][rc[1:0]];
        end
        else begin
            w = INTERIOR3[ad[1:0]];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bgbm_ifs.sv
// ----------------------------------------------------------------------------
// bgbm channel interfaces
// Valid/ready channels for input samples and for product beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgbm_sample_if;
    import bgbm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bgbm_product_if;
    import bgbm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t product;
    row_t    row_index;
    logic    end_of_vector;

    modport source (output valid, output product, output row_index, output end_of_vector,
                    input ready);
    modport sink   (input valid, input product, input row_index, input end_of_vector,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/bgbm_front.sv
// ----------------------------------------------------------------------------
// bgbm_front
// Accepts samples, keeps the sample window and position in the vector, and
// queues a job for every sample that releases at least one row.
// ----------------------------------------------------------------------------
`default_nettype none

module bgbm_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bgbm_pkg::cfg_t        cfg,
    input  logic                  restart,
    bgbm_sample_if.sink           samples,
    input  logic                  queue_full,
    output bgbm_pkg::queue_wr_t   wr
);
    import bgbm_pkg::*;

    sample_t    window_reg [WIN_DEPTH];
    len_t       count_reg;
    len_t       count_next;
    len_t       k;
    logic [1:0] lag;
    logic       last;
    logic       emit;
    logic       accept;

    // A sample is taken whenever the queue has room.
    assign samples.ready = !queue_full;
    assign accept        = samples.valid && samples.ready;

    // Classify the sample: its index, whether it closes the vector, whether a row is due.
    always_comb
    begin
        k    = (count_reg >= cfg.len) ? '0 : count_reg;
        lag  = cfg.ord3 ? 2'd2 : 2'd1;
        last = (k == cfg.len - LEN_W'(1));
        emit = last || (k >= LEN_W'(lag));
    end

    // Build the job from the incoming sample and the window.
    always_comb
    begin
        wr.push        = accept && emit;
        wr.job.taps[0] = samples.sample;
        for (int i = 1; i < TAPS; i++)
        begin
            wr.job.taps[i] = window_reg[i-1];
        end
        wr.job.k    = k[ROW_W-1:0];
        wr.job.last = last;
    end

    // Position in the vector; a register write starts a new vector.
    always_comb
    begin
        count_next = count_reg;
        if (restart)
        begin
            count_next = '0;
        end
        else if (accept)
        begin
            count_next = last ? '0 : k + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Sample window; columns before the vector start carry zero weight.
    // It is cleared at reset so that those columns never hold an unknown value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            window_reg[0] <= samples.sample;
            for (int i = 1; i < WIN_DEPTH; i++)
            begin
                window_reg[i] <= window_reg[i-1];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bgbm_queue.sv
// ----------------------------------------------------------------------------
// bgbm_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bgbm_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bgbm_pkg::queue_wr_t   wr,
    input  logic                  pop,
    output logic                  full,
    output bgbm_pkg::queue_rd_t   rd
);
    import bgbm_pkg::*;

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd.valid = (count_reg != '0);
    assign rd.job   = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + PTR_W'(1);
        end
        case ({wr.push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[wr_ptr_reg] <= wr.job;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bgbm_back.sv
// ----------------------------------------------------------------------------
// bgbm_back
// Expands each job into its rows and computes one row per cycle, unless products
// stalls, through a coefficient stage, a multiply stage, a partial-sum stage and
// the output register, where the sum is rounded and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module bgbm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bgbm_pkg::cfg_t        cfg,
    input  bgbm_pkg::queue_rd_t   rd,
    output logic                  pop,
    bgbm_product_if.source        products
);
    import bgbm_pkg::*;

    logic [1:0] step_reg;
    logic [1:0] step_next;
    logic [1:0] lag;
    logic       adv;
    logic       issue;
    logic       final_row;
    row_t       row_c;
    tag_t       tag_c;
    coef_t      coef_c [TAPS];
    sample_t    x_c [TAPS];

    logic       valid_s0_reg;
    coef_t      coef_s0_reg [TAPS];
    sample_t    x_s0_reg [TAPS];
    tag_t       tag_s0_reg;

    logic       valid_s1_reg;
    prod_t      prod_s1_reg [TAPS];
    tag_t       tag_s1_reg;

    logic       valid_s2_reg;
    sum_t       psum_s2_reg [3];
    tag_t       tag_s2_reg;

    logic       out_valid_reg;
    sample_t    product_reg;
    tag_t       tag_out_reg;

    sum_t                       total;
    logic signed [SUM_W-FRAC_BITS-1:0] rounded;
    sample_t                    product_next;

    // The whole pipeline moves when the output register is free or being emptied.
    assign adv       = !out_valid_reg || products.ready;
    assign issue     = adv && rd.valid;
    assign lag       = cfg.ord3 ? 2'd2 : 2'd1;
    assign final_row = !rd.job.last || (step_reg == lag);
    assign pop       = issue && final_row;

    // Row sequencer: one row per job, or lag+1 rows for the last sample of a vector.
    always_comb
    begin
        step_next = step_reg;
        if (issue)
        begin
            step_next = final_row ? 2'd0 : step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Coefficient and sample selection for the five columns of the current row.
    always_comb
    begin
        logic signed [2:0] d;
        logic signed [3:0] j;
        row_c     = rd.job.k - ROW_W'(lag) + ROW_W'(step_reg);
        tag_c.row = row_c;
        tag_c.eov = ({1'b0, row_c} == cfg.len - LEN_W'(1));
        for (int t = 0; t < TAPS; t++)
        begin
            d         = 3'(t - 2);
            j         = $signed({2'b00, lag}) - $signed({2'b00, step_reg}) - 4'(d);
            coef_c[t] = coef_fn(cfg, row_c, d);
            x_c[t]    = (j < 0) ? '0 : rd.job.taps[j[2:0]];
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s0_reg  <= 1'b0;
            valid_s1_reg  <= 1'b0;
            valid_s2_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_s0_reg  <= issue;
            valid_s1_reg  <= valid_s0_reg;
            valid_s2_reg  <= valid_s1_reg;
            out_valid_reg <= valid_s2_reg;
        end
    end

    // Final sum, which already carries the rounding half, shifted down by 30 bits
    // and saturated to the sample range.
    always_comb
    begin
        total   = psum_s2_reg[0] + psum_s2_reg[1] + psum_s2_reg[2];
        rounded = (SUM_W-FRAC_BITS)'(total >>> FRAC_BITS);
        if (rounded[SUM_W-FRAC_BITS-1:SAMPLE_W-1] == '0 ||
            rounded[SUM_W-FRAC_BITS-1:SAMPLE_W-1] == '1)
        begin
            product_next = rounded[SAMPLE_W-1:0];
        end
        else if (rounded[SUM_W-FRAC_BITS-1])
        begin
            product_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            product_next = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    // Pipeline payload: coefficients, products, partial sums, result.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int t = 0; t < TAPS; t++)
            begin
                coef_s0_reg[t] <= coef_c[t];
                x_s0_reg[t]    <= x_c[t];
                prod_s1_reg[t] <= x_s0_reg[t] * $signed({1'b0, coef_s0_reg[t]});
            end
            tag_s0_reg     <= tag_c;
            tag_s1_reg     <= tag_s0_reg;
            psum_s2_reg[0] <= SUM_W'(prod_s1_reg[0]) + SUM_W'(prod_s1_reg[1]);
            psum_s2_reg[1] <= SUM_W'(prod_s1_reg[2]) + SUM_W'(prod_s1_reg[3]);
            psum_s2_reg[2] <= SUM_W'(prod_s1_reg[4]) + (SUM_W'(1) <<< (FRAC_BITS - 1));
            tag_s2_reg     <= tag_s1_reg;
            product_reg    <= product_next;
            tag_out_reg    <= tag_s2_reg;
        end
    end

    assign products.valid         = out_valid_reg;
    assign products.product       = product_reg;
    assign products.row_index     = tag_out_reg.row;
    assign products.end_of_vector = tag_out_reg.eov;

endmodule

`default_nettype wire

FILE: rtl/bspline_gram_banded_multiply.sv
// ----------------------------------------------------------------------------
// bspline_gram_banded_multiply
// Streams a vector through the banded B-spline Gram matrix: y = G x.
//
// Channel    Way   Beat contents
// samples    in    sample, signed Q1.30
// products   out   product (signed Q1.30, saturated), row_index, end_of_vector
// wr_*       in    register write: wr_index selects, wr_data carries the value
//
// One sample is accepted per cycle while the queue has room. A sample from index 1
// (order 2) or 2 (order 3) on releases one product; the last sample of a vector
// releases two (order 2) or three (order 3), one per cycle unless products stalls,
// set by the one-row-per-cycle multiply pipeline. A product passes the job queue,
// the coefficient, multiply and partial-sum stages and the output register. Reset
// clears control state and the sample window and needs no clearing pass. A stall on
// products freezes the back pipeline; the four-job queue takes samples until full.
// ----------------------------------------------------------------------------
`default_nettype none

module bspline_gram_banded_multiply (
    input  logic                         clk,
    input  logic                         rst_n,
    bgbm_sample_if.sink                  samples,
    bgbm_product_if.source               products,
    input  logic                         wr_en,
    input  logic [1:0]                   wr_index,
    input  logic [bgbm_pkg::LEN_W-1:0]   wr_data
);
    import bgbm_pkg::*;

    len_t       length_reg;
    logic [1:0] order_reg;
    logic [1:0] mode_reg;
    logic       restart;
    cfg_t       cfg;
    queue_wr_t  q_wr;
    queue_rd_t  q_rd;
    logic       q_full;
    logic       q_pop;

    // Configuration registers; any write to a listed register restarts the vector.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= MIN_LENGTH;
            order_reg  <= RESET_ORDER;
            mode_reg   <= RESET_MODE;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_LENGTH:   length_reg <= wr_data;
                REG_ORDER:    order_reg  <= wr_data[1:0];
                REG_BOUNDARY: mode_reg   <= wr_data[1:0];
                default:      ;
            endcase
        end
    end

    assign restart = wr_en && (wr_index == REG_LENGTH || wr_index == REG_ORDER ||
                               wr_index == REG_BOUNDARY);

    // Effective configuration: length clamped, unknown order acts as order 2.
    always_comb
    begin
        cfg.ord3 = (order_reg == ORDER_PENTA);
        cfg.mode = mode_reg;
        if (length_reg < MIN_LENGTH)
        begin
            cfg.len = MIN_LENGTH;
        end
        else if (length_reg > MAX_LENGTH)
        begin
            cfg.len = MAX_LENGTH;
        end
        else
        begin
            cfg.len = length_reg;
        end
    end

    bgbm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .restart    (restart),
        .samples    (samples),
        .queue_full (q_full),
        .wr         (q_wr)
    );

    bgbm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .pop   (q_pop),
        .full  (q_full),
        .rd    (q_rd)
    );

    bgbm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .rd       (q_rd),
        .pop      (q_pop),
        .products (products)
    );

endmodule

`default_nettype wire

FILE: rtl/bgbm_checker.sv
// ----------------------------------------------------------------------------
// bgbm_checker
// Port-level checks on the product stream of the banded Gram multiply.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bspline_gram_banded_multiply_assert.svh"

module bgbm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bgbm_pkg::SAMPLE_W-1:0] product,
    input logic [bgbm_pkg::ROW_W-1:0]    row_index,
    input logic                          end_of_vector,
    input logic                          wr_en,
    input logic [1:0]                    wr_index
);
    import bgbm_pkg::*;

    row_t exp_row_reg;
    row_t exp_row_next;
    logic out_beat;
    logic restart;

    assign out_beat = out_valid && out_ready;

    // Only a write to a listed register starts a new vector.
    assign restart = wr_en && (wr_index == REG_LENGTH || wr_index == REG_ORDER ||
                               wr_index == REG_BOUNDARY);

    // Rows leave in order from zero, and start over after the end of a vector.
    always_comb
    begin
        exp_row_next = exp_row_reg;
        if (restart)
        begin
            exp_row_next = '0;
        end
        else if (out_beat)
        begin
            exp_row_next = end_of_vector ? '0 : row_index + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_row_reg <= '0;
        end
        else
        begin
            exp_row_reg <= exp_row_next;
        end
    end

    `BGBM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(product) && $stable(row_index), "product beat changed while stalled")
    `BGBM_ASSERT_SAME(a_row_order, clk, rst_n, out_beat, row_index == exp_row_reg, "product row out of order")
    `BGBM_ASSERT_SAME(a_eov_row, clk, rst_n, out_valid && end_of_vector, row_index >= ROW_W'(4), "end of vector on a row below the minimum length")

endmodule

bind bspline_gram_banded_multiply bgbm_checker u_bgbm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (products.valid),
    .out_ready     (products.ready),
    .product       (products.product),
    .row_index     (products.row_index),
    .end_of_vector (products.end_of_vector),
    .wr_en         (wr_en),
    .wr_index      (wr_index)
);

`default_nettype wire
